@@ hdl/mtep_pkg.sv @@
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared widths, status codes, parse phases and the command passed from the
// byte parser to the timing back end.
// ----------------------------------------------------------------------------
package mtep_pkg;

	localparam int TIME_BITS = 32;
	localparam int DELTA_W   = 28;
	localparam int SCALE_W   = 10;
	localparam int PROD_W    = DELTA_W + SCALE_W;
	localparam int SUM_W     = ((TIME_BITS > PROD_W) ? TIME_BITS : PROD_W) + 1;
	localparam int TICK_W    = 32;
	localparam int EXT_W     = (TIME_BITS > TICK_W) ? TIME_BITS : TICK_W;

	localparam logic [SUM_W-1:0] TIME_MAX =
		{{(SUM_W - TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};

	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

	localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1);

	localparam logic [3:0] KIND_NONE      = 4'h0;
	localparam logic [3:0] KIND_NOTE_OFF  = 4'h8;
	localparam logic [3:0] KIND_NOTE_ON   = 4'h9;
	localparam logic [3:0] KIND_PROGRAM   = 4'hC;
	localparam logic [3:0] KIND_PRESSURE  = 4'hD;
	localparam logic [3:0] KIND_SYSTEM    = 4'hF;

	localparam logic [7:0] ST_SYSEX       = 8'hF0;
	localparam logic [7:0] ST_SYSEX_ESC   = 8'hF7;
	localparam logic [7:0] ST_META        = 8'hFF;
	localparam logic [7:0] META_END       = 8'd47;

	localparam logic [1:0] EV_NOTE_OFF    = 2'd0;
	localparam logic [1:0] EV_NOTE_ON     = 2'd1;
	localparam logic [1:0] EV_END         = 2'd2;

	typedef enum logic [2:0] {
		PH_DELTA     = 3'd0,
		PH_STATUS    = 3'd1,
		PH_DATA1     = 3'd2,
		PH_DATA2     = 3'd3,
		PH_SKIP      = 3'd4,
		PH_META_TYPE = 3'd5,
		PH_LEN       = 3'd6,
		PH_DONE      = 3'd7
	} phase_t;

	typedef struct packed {
		logic               clear;
		logic               add;
		logic               emit;
		logic [DELTA_W-1:0] delta;
		logic [1:0]         kind;
		logic [3:0]         channel;
		logic [6:0]         note;
		logic [6:0]         velocity;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ hdl/mtep_front.sv @@
// ----------------------------------------------------------------------------
// MIDI track event parser front end
// Walks the track byte stream, follows running status and skips unwanted
// messages, and issues time and event commands to the back end.
// ----------------------------------------------------------------------------
module mtep_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     data_byte,
	input  logic           track_start,
	input  logic           accept,
	output logic           cmd_valid,
	output mtep_pkg::cmd_t cmd
);

	mtep_pkg::phase_t                phase_q, eff_phase, phase_d;
	logic [mtep_pkg::DELTA_W-1:0]    acc_q, eff_acc, acc_d, acc_shift;
	logic [1:0]                      cnt_q, eff_cnt, cnt_d;
	logic [3:0]                      run_kind_q, eff_run_kind, run_kind_d;
	logic [3:0]                      run_ch_q, eff_run_ch, run_ch_d;
	logic [6:0]                      first_q, eff_first, first_d;
	logic [mtep_pkg::DELTA_W-1:0]    skip_q, eff_skip, skip_d, skip_shift;
	logic                            quantity_end;
	logic                            one_data;
	logic [3:0]                      hi;

	// A track start clears the parse state before its own byte is parsed.
	always_comb begin
		eff_phase    = track_start ? mtep_pkg::PH_DELTA : phase_q;
		eff_acc      = track_start ? '0 : acc_q;
		eff_cnt      = track_start ? '0 : cnt_q;
		eff_run_kind = track_start ? mtep_pkg::KIND_NONE : run_kind_q;
		eff_run_ch   = track_start ? '0 : run_ch_q;
		eff_first    = track_start ? '0 : first_q;
		eff_skip     = track_start ? '0 : skip_q;
	end

	assign acc_shift    = {eff_acc[mtep_pkg::DELTA_W-8:0], data_byte[6:0]};
	assign skip_shift   = {eff_skip[mtep_pkg::DELTA_W-8:0], data_byte[6:0]};
	assign quantity_end = !data_byte[7] || (eff_cnt == 2'd3);
	assign hi           = data_byte[7:4];
	assign one_data     = (eff_run_kind == mtep_pkg::KIND_PROGRAM) ||
	                      (eff_run_kind == mtep_pkg::KIND_PRESSURE);

	always_comb begin
		phase_d    = eff_phase;
		acc_d      = eff_acc;
		cnt_d      = eff_cnt;
		run_kind_d = eff_run_kind;
		run_ch_d   = eff_run_ch;
		first_d    = eff_first;
		skip_d     = eff_skip;
		unique case (eff_phase)
			mtep_pkg::PH_DELTA: begin
				if (quantity_end) begin
					acc_d   = '0;
					cnt_d   = '0;
					phase_d = mtep_pkg::PH_STATUS;
				end else begin
					acc_d = acc_shift;
					cnt_d = eff_cnt + 2'd1;
				end
			end
			mtep_pkg::PH_STATUS: begin
				if (!data_byte[7]) begin
					if (eff_run_kind == mtep_pkg::KIND_NONE) begin
						phase_d = mtep_pkg::PH_DELTA;
					end else if (eff_run_kind == mtep_pkg::KIND_NOTE_OFF ||
					             eff_run_kind == mtep_pkg::KIND_NOTE_ON) begin
						first_d = data_byte[6:0];
						phase_d = mtep_pkg::PH_DATA2;
					end else if (one_data) begin
						phase_d = mtep_pkg::PH_DELTA;
					end else begin
						skip_d  = mtep_pkg::DELTA_W'(1);
						phase_d = mtep_pkg::PH_SKIP;
					end
				end else if (hi != mtep_pkg::KIND_SYSTEM) begin
					run_kind_d = hi;
					run_ch_d   = data_byte[3:0];
					if (hi == mtep_pkg::KIND_NOTE_OFF || hi == mtep_pkg::KIND_NOTE_ON) begin
						phase_d = mtep_pkg::PH_DATA1;
					end else if (hi == mtep_pkg::KIND_PROGRAM ||
					             hi == mtep_pkg::KIND_PRESSURE) begin
						skip_d  = mtep_pkg::DELTA_W'(1);
						phase_d = mtep_pkg::PH_SKIP;
					end else begin
						skip_d  = mtep_pkg::DELTA_W'(2);
						phase_d = mtep_pkg::PH_SKIP;
					end
				end else if (data_byte == mtep_pkg::ST_META) begin
					phase_d = mtep_pkg::PH_META_TYPE;
				end else if (data_byte == mtep_pkg::ST_SYSEX ||
				             data_byte == mtep_pkg::ST_SYSEX_ESC) begin
					skip_d  = '0;
					cnt_d   = '0;
					phase_d = mtep_pkg::PH_LEN;
				end else begin
					phase_d = mtep_pkg::PH_DELTA;
				end
			end
			mtep_pkg::PH_DATA1: begin
				first_d = data_byte[6:0];
				phase_d = mtep_pkg::PH_DATA2;
			end
			mtep_pkg::PH_DATA2: begin
				phase_d = mtep_pkg::PH_DELTA;
			end
			mtep_pkg::PH_SKIP: begin
				if (eff_skip <= mtep_pkg::DELTA_W'(1)) begin
					skip_d  = '0;
					phase_d = mtep_pkg::PH_DELTA;
				end else begin
					skip_d = eff_skip - mtep_pkg::DELTA_W'(1);
				end
			end
			mtep_pkg::PH_META_TYPE: begin
				if (data_byte == mtep_pkg::META_END) begin
					phase_d = mtep_pkg::PH_DONE;
				end else begin
					skip_d  = '0;
					cnt_d   = '0;
					phase_d = mtep_pkg::PH_LEN;
				end
			end
			mtep_pkg::PH_LEN: begin
				skip_d = skip_shift;
				if (quantity_end) begin
					cnt_d   = '0;
					phase_d = (skip_shift == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
				end else begin
					cnt_d = eff_cnt + 2'd1;
				end
			end
			mtep_pkg::PH_DONE: begin
				phase_d = mtep_pkg::PH_DONE;
			end
		endcase
	end

	always_comb begin
		cmd_valid    = track_start;
		cmd.clear    = track_start;
		cmd.add      = 1'b0;
		cmd.emit     = 1'b0;
		cmd.delta    = acc_shift;
		cmd.kind     = mtep_pkg::EV_NOTE_OFF;
		cmd.channel  = eff_run_ch;
		cmd.note     = eff_first;
		cmd.velocity = data_byte[6:0];
		unique case (eff_phase)
			mtep_pkg::PH_DELTA: begin
				if (quantity_end) begin
					cmd_valid = 1'b1;
					cmd.add   = 1'b1;
				end
			end
			mtep_pkg::PH_DATA2: begin
				cmd_valid = 1'b1;
				cmd.emit  = 1'b1;
				if (eff_run_kind == mtep_pkg::KIND_NOTE_ON && data_byte[6:0] != 7'd0) begin
					cmd.kind = mtep_pkg::EV_NOTE_ON;
				end
			end
			mtep_pkg::PH_META_TYPE: begin
				if (data_byte == mtep_pkg::META_END) begin
					cmd_valid    = 1'b1;
					cmd.emit     = 1'b1;
					cmd.kind     = mtep_pkg::EV_END;
					cmd.channel  = '0;
					cmd.note     = '0;
					cmd.velocity = '0;
				end
			end
			mtep_pkg::PH_STATUS, mtep_pkg::PH_DATA1, mtep_pkg::PH_SKIP,
			mtep_pkg::PH_LEN, mtep_pkg::PH_DONE: begin
				cmd.emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= mtep_pkg::PH_DELTA;
			acc_q      <= '0;
			cnt_q      <= '0;
			run_kind_q <= mtep_pkg::KIND_NONE;
			run_ch_q   <= '0;
			first_q    <= '0;
			skip_q     <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			acc_q      <= acc_d;
			cnt_q      <= cnt_d;
			run_kind_q <= run_kind_d;
			run_ch_q   <= run_ch_d;
			first_q    <= first_d;
			skip_q     <= skip_d;
		end
	end

endmodule

@@ hdl/mtep_queue.sv @@
// ----------------------------------------------------------------------------
// MIDI track event parser command queue
// A short first-in first-out store of commands between front and back end.
// ----------------------------------------------------------------------------
module mtep_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mtep_pkg::cmd_t    push_cmd,
	input  logic              pop,
	output mtep_pkg::cmd_t    head_cmd,
	output mtep_pkg::q_stat_t stat
);

	mtep_pkg::cmd_t                 mem_q [mtep_pkg::Q_DEPTH];
	logic [mtep_pkg::Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [mtep_pkg::Q_CNT_W-1:0]   count_q;

	assign stat.full  = (count_q == mtep_pkg::Q_CNT_W'(mtep_pkg::Q_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == mtep_pkg::Q_PTR_W'(mtep_pkg::Q_DEPTH - 1)) ?
				            '0 : wr_ptr_q + mtep_pkg::Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == mtep_pkg::Q_PTR_W'(mtep_pkg::Q_DEPTH - 1)) ?
				            '0 : rd_ptr_q + mtep_pkg::Q_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + mtep_pkg::Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - mtep_pkg::Q_CNT_W'(1);
			end
		end
	end

endmodule

@@ hdl/mtep_back.sv @@
// ----------------------------------------------------------------------------
// MIDI track event parser back end
// Scales delta times, keeps the saturating absolute tick time and drives the
// event output register.
// ----------------------------------------------------------------------------
module mtep_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mtep_pkg::SCALE_W-1:0]  cfg_wdata,
	input  logic                          q_empty,
	input  mtep_pkg::cmd_t                head_cmd,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    out_kind,
	output logic [3:0]                    out_channel,
	output logic [6:0]                    out_note,
	output logic [6:0]                    out_velocity,
	output logic [mtep_pkg::TICK_W-1:0]   out_tick
);

	logic [mtep_pkg::SCALE_W-1:0]   scale_q;
	logic                           valid_s1;
	mtep_pkg::cmd_t                 cmd_s1;
	logic [mtep_pkg::PROD_W-1:0]    prod_s1;
	logic [mtep_pkg::TIME_BITS-1:0] time_q, base, time_d;
	logic [mtep_pkg::SUM_W-1:0]     sum;
	logic [mtep_pkg::EXT_W-1:0]     base_ext;
	logic                           go_s1, load_s1;
	logic                           out_valid_q;

	assign go_s1   = valid_s1 && !(cmd_s1.emit && out_valid_q && !out_ready);
	assign load_s1 = !valid_s1 || go_s1;
	assign pop     = load_s1 && !q_empty;

	assign base     = cmd_s1.clear ? '0 : time_q;
	assign sum      = mtep_pkg::SUM_W'(base) + mtep_pkg::SUM_W'(prod_s1);
	assign time_d   = !cmd_s1.add ? base :
	                  (sum > mtep_pkg::TIME_MAX) ? {mtep_pkg::TIME_BITS{1'b1}} :
	                  sum[mtep_pkg::TIME_BITS-1:0];
	assign base_ext = mtep_pkg::EXT_W'(base);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= mtep_pkg::SCALE_RESET;
		end else if (cfg_we) begin
			scale_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			time_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= !q_empty;
			end
			if (go_s1) begin
				time_q <= time_d;
			end
			if (go_s1 && cmd_s1.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1  <= head_cmd;
			prod_s1 <= mtep_pkg::PROD_W'(head_cmd.delta) * mtep_pkg::PROD_W'(scale_q);
		end
		if (go_s1 && cmd_s1.emit) begin
			out_kind     <= cmd_s1.kind;
			out_channel  <= cmd_s1.channel;
			out_note     <= cmd_s1.note;
			out_velocity <= cmd_s1.velocity;
			out_tick     <= base_ext[mtep_pkg::TICK_W-1:0];
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ hdl/midi_track_event_parser.sv @@
// ----------------------------------------------------------------------------
// MIDI track event parser
// Parses Standard MIDI File track bytes into note and end-of-track events.
// ----------------------------------------------------------------------------
// The block takes one track byte per cycle on the slave stream, with
// s_tuser[0] set on the first byte of a track, and delivers note-off,
// note-on and end-of-track events on the master stream with a saturating
// absolute tick time. The byte parser accepts a byte in every cycle while its
// four-entry command queue has room; each byte yields at most one command.
// The back end takes one command per cycle through a two-stage path: the
// delta-by-scale multiply in the first stage and the saturating time add in
// the second. An event command is held in the first stage while an earlier
// event waits to be taken. With the master side ready, an event passes from
// the queue through the first stage into the output register.
// The queue lets the next byte in while an event waits to be taken, while it has room.
// The tick scale is written through cfg_we and cfg_wdata; the user must do so
// only while the block is idle, as the block does not enforce it. It resets to one.
module midi_track_event_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [9:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte[7:0]
	input  logic [0:0]  s_tuser,   // track_start[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // channel[3:0], note_number[10:4],
	                               // velocity[17:11], tick_time[49:18], zero
	output logic [1:0]  m_tuser    // event_kind[1:0]
);

	logic              accept;
	logic              cmd_valid;
	mtep_pkg::cmd_t    cmd, head_cmd;
	logic              q_push, q_pop;
	mtep_pkg::q_stat_t q_stat;
	logic [3:0]        out_channel;
	logic [6:0]        out_note, out_velocity;
	logic [mtep_pkg::TICK_W-1:0] out_tick;

	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;
	assign q_push   = accept && cmd_valid;

	mtep_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (s_tdata),
		.track_start (s_tuser[0]),
		.accept      (accept),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd)
	);

	mtep_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (cmd),
		.pop      (q_pop),
		.head_cmd (head_cmd),
		.stat     (q_stat)
	);

	mtep_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.q_empty      (q_stat.empty),
		.head_cmd     (head_cmd),
		.pop          (q_pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_kind     (m_tuser),
		.out_channel  (out_channel),
		.out_note     (out_note),
		.out_velocity (out_velocity),
		.out_tick     (out_tick)
	);

	assign m_tdata = {6'd0, out_tick, out_velocity, out_note, out_channel};

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !q_push)
		else $error("Command pushed into a full queue.");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty |-> !q_pop)
		else $error("Command popped from an empty queue.");

	a_end_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == mtep_pkg::EV_END) |-> (m_tdata[17:0] == 18'd0))
		else $error("End-of-track event carries note fields.");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == mtep_pkg::EV_NOTE_OFF || m_tuser == mtep_pkg::EV_NOTE_ON ||
		              m_tuser == mtep_pkg::EV_END))
		else $error("Event of unknown kind delivered.");

endmodule
